### design/spfd_pkg.sv
// Shared types and constants for the sparse pixel frame decoder.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package spfd_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = 2;
    localparam int unsigned QCNT_W      = 3;

    typedef struct packed {
        logic [15:0] data_word;
        logic [10:0] words_left;
        logic        frame_sel;
    } in_t;

    typedef struct packed {
        logic [11:0] hit_column;
        logic [10:0] hit_row;
        logic        hit_pivot;
        logic        hit_frame;
        logic        hit_last;
    } out_t;

    // One decoded run word waiting for expansion
    typedef struct packed {
        logic [10:0] column;
        logic [1:0]  len;
        logic [10:0] row;
        logic        pivot;
        logic        frame;
    } run_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [1:0] {
        MODE_HEADER,
        MODE_RUNS,
        MODE_DISCARD
    } mode_t;

endpackage

`default_nettype wire

### design/spfd_front.sv
// Word parser: tracks header / run / discard state and emits run entries.
// Depends on spfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spfd_front #(
    parameter int unsigned MAX_FRAME_WORDS = 2048
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire spfd_pkg::in_t    in_data,
    input  wire logic             cfg_wr_en,
    input  wire logic [13:0]      cfg_wr_data,
    output logic                  push,
    output spfd_pkg::run_t        push_data
);
    import spfd_pkg::*;

    localparam int unsigned LEFT_CAP =
        (MAX_FRAME_WORDS > 2048) ? 2047 : MAX_FRAME_WORDS - 1;

    mode_t       mode_reg, mode_next;
    logic [3:0]  runs_reg, runs_next;
    logic [10:0] row_reg, row_next;
    logic        pivot_reg, pivot_next;
    logic [13:0] pivot_pixel_reg;

    logic [10:0] left;
    logic [3:0]  nruns;
    logic [10:0] hdr_row;
    logic [3:0]  runs_dec;

    always_comb
    begin
        if (32'(in_data.words_left) > LEFT_CAP)
            left = LEFT_CAP[10:0];
        else
            left = in_data.words_left;
    end

    assign nruns    = in_data.data_word[3:0];
    assign hdr_row  = in_data.data_word[14:4];
    assign runs_dec = runs_reg - 4'd1;

    // next state
    always_comb
    begin
        mode_next  = mode_reg;
        runs_next  = runs_reg;
        row_next   = row_reg;
        pivot_next = pivot_reg;
        if (accept)
        begin
            unique case (mode_reg)
                MODE_HEADER:
                begin
                    if (left != 11'd0)
                    begin
                        if ({7'd0, nruns} > left)
                        begin
                            mode_next = MODE_DISCARD;
                            runs_next = 4'd0;
                        end
                        else
                        begin
                            row_next   = hdr_row;
                            pivot_next = (hdr_row >= {1'b0, pivot_pixel_reg[13:4]});
                            runs_next  = nruns;
                            mode_next  = (nruns != 4'd0) ? MODE_RUNS : MODE_HEADER;
                        end
                    end
                end
                MODE_RUNS:
                begin
                    runs_next = runs_dec;
                    if (runs_dec == 4'd0)
                        mode_next = MODE_HEADER;
                end
                default:
                begin
                    mode_next = MODE_DISCARD;
                end
            endcase
            // end of frame always resyncs to a header
            if (left == 11'd0)
            begin
                mode_next = MODE_HEADER;
                runs_next = 4'd0;
            end
        end
    end

    // outputs
    always_comb
    begin
        push            = accept && (mode_reg == MODE_RUNS);
        push_data.column = in_data.data_word[12:2];
        push_data.len    = in_data.data_word[1:0];
        push_data.row    = row_reg;
        push_data.pivot  = pivot_reg;
        push_data.frame  = in_data.frame_sel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_HEADER;
            runs_reg        <= 4'd0;
            row_reg         <= 11'd0;
            pivot_reg       <= 1'b0;
            pivot_pixel_reg <= 14'd0;
        end
        else
        begin
            mode_reg  <= mode_next;
            runs_reg  <= runs_next;
            row_reg   <= row_next;
            pivot_reg <= pivot_next;
            if (cfg_wr_en)
                pivot_pixel_reg <= cfg_wr_data;
        end
    end

endmodule

`default_nettype wire

### design/spfd_queue.sv
// Short register queue of run entries between parser and expander.
// Depends on spfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spfd_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire spfd_pkg::run_t      push_data,
    input  wire logic                pop,
    output spfd_pkg::run_t           head,
    output spfd_pkg::q_status_t      status
);
    import spfd_pkg::*;

    run_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### design/spfd_back.sv
// Run expander: turns each queued run into 1 to 4 hits, one per beat,
// through a registered output stage. Depends on spfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spfd_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire spfd_pkg::run_t      head,
    input  wire spfd_pkg::q_status_t status,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output spfd_pkg::out_t           out_data
);
    import spfd_pkg::*;

    logic [1:0] offset_reg, offset_next;
    logic       valid_reg, valid_next;
    out_t       data_reg, data_next;
    logic       load;
    logic       at_end;

    assign load   = !status.empty && (!valid_reg || !out_stall);
    assign at_end = (offset_reg == head.len);
    assign pop    = load && at_end;

    always_comb
    begin
        data_next.hit_column = {1'b0, head.column} + {10'd0, offset_reg};
        data_next.hit_row    = head.row;
        data_next.hit_pivot  = head.pivot;
        data_next.hit_frame  = head.frame;
        data_next.hit_last   = at_end;

        if (load)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;

        if (load)
            offset_next = at_end ? 2'd0 : offset_reg + 2'd1;
        else
            offset_next = offset_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            offset_reg <= 2'd0;
        end
        else
        begin
            valid_reg  <= valid_next;
            offset_reg <= offset_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

### design/sparse_pixel_frame_decoder.sv
// Sparse pixel frame decoder, top level.
// Input channel: one 16-bit frame word per beat with its words_left count and
//   frame index; header words set the row, run words expand into pixel hits.
// Output channel: one hit per beat (column, row, pivot flag, frame, last flag).
// Configuration: cfg_wr_en writes the 14-bit pivot pixel; write only when idle.
// Throughput: one input word per cycle while runs are short enough for the
//   output to keep up and the receiver does not stall; a run word expands into
//   1 to 4 hits (run length), set by the single-hit-per-cycle expander.
// An accepted run word reaches the output through the queue write, then the
//   output register.
// A four-entry run queue sits between the parser and the expander; when it
//   fills, in_stall rises. Header and discarded words still wait for a free
//   slot but produce no hits.
// Receiver stall holds the current hit steady; the expander and then the
//   queue back up, and the parser keeps taking words until the queue is full.
// Reset (rst_n, async low) clears the parser to expect a header, empties the
//   queue, drops any pending hit and resets the pivot pixel to 0.
// Depends on spfd_pkg, spfd_front, spfd_queue, spfd_back.
`timescale 1ns / 1ps
`default_nettype none

module sparse_pixel_frame_decoder #(
    parameter int unsigned MAX_FRAME_WORDS = 2048
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire spfd_pkg::in_t   in_data,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output spfd_pkg::out_t       out_data,
    input  wire logic            cfg_wr_en,
    input  wire logic [13:0]     cfg_wr_data
);
    import spfd_pkg::*;

    logic      accept;
    logic      push;
    run_t      push_data;
    logic      pop;
    run_t      head;
    q_status_t status;

    assign in_stall = status.full;
    assign accept   = in_valid && !status.full;

    spfd_front #(
        .MAX_FRAME_WORDS(MAX_FRAME_WORDS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_data    (in_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .push       (push),
        .push_data  (push_data)
    );

    spfd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_data),
        .pop      (pop),
        .head     (head),
        .status   (status)
    );

    spfd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .status   (status),
        .pop      (pop),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

endmodule

`default_nettype wire

### tb/sv/sparse_pixel_frame_decoder_check.sv
// Checker for the sparse pixel frame decoder: watches both channels and the
// pivot register port, predicts the hits of every accepted word and compares.
// Depends on spfd_pkg for the beat types and the parser modes.
`timescale 1ns / 1ps

module sparse_pixel_frame_decoder_check (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic           in_stall,
    input  wire spfd_pkg::in_t  in_data,
    input  wire logic           out_valid,
    input  wire logic           out_stall,
    input  wire spfd_pkg::out_t out_data,
    input  wire logic           cfg_wr_en,
    input  wire logic [13:0]    cfg_wr_data,
    output int                  hit_errors,
    output int                  hits_owed
);
    import spfd_pkg::*;

    localparam int REPORT_LIMIT = 10;

    out_t        pending_hits[$];
    mode_t       parse_state;
    logic [3:0]  runs_owed;
    logic [10:0] cur_row;
    logic        cur_pivot;
    logic [13:0] pivot_pixel;

    // Header/run parser: queues the hits a word expands into.
    task automatic expand_word(input in_t w);
        logic [10:0] left;
        logic [3:0]  nruns;
        logic [10:0] row;
        logic [10:0] col;
        logic [1:0]  len;
        out_t        hit;
        int          j;
        // an 11-bit count never reaches the 2048-word saturation point
        left = w.words_left;
        case (parse_state)
            MODE_HEADER:
            begin
                // the last word of a frame is never a header
                if (left != 0)
                begin
                    nruns = w.data_word[3:0];
                    row   = w.data_word[14:4];
                    if (nruns > left)
                    begin
                        parse_state = MODE_DISCARD;
                        runs_owed   = '0;
                    end
                    else
                    begin
                        cur_row     = row;
                        cur_pivot   = (row >= (pivot_pixel >> 4));
                        runs_owed   = nruns;
                        parse_state = (nruns != 0) ? MODE_RUNS : MODE_HEADER;
                    end
                end
            end
            MODE_RUNS:
            begin
                col = w.data_word[12:2];
                len = w.data_word[1:0];
                for (j = 0; j <= len; j++)
                begin
                    hit.hit_column = 12'({1'b0, col} + j);
                    hit.hit_row    = cur_row;
                    hit.hit_pivot  = cur_pivot;
                    hit.hit_frame  = w.frame_sel;
                    hit.hit_last   = (j == len);
                    pending_hits   = {pending_hits, hit};
                end
                runs_owed = runs_owed - 4'd1;
                if (runs_owed == 0)
                    parse_state = MODE_HEADER;
            end
            default:
            begin
                // discard until the frame ends
            end
        endcase
        if (left == 0)
        begin
            parse_state = MODE_HEADER;
            runs_owed   = '0;
        end
    endtask

    task automatic check_hit(input out_t got);
        out_t want;
        if (pending_hits.size() == 0)
        begin
            hit_errors++;
            if (hit_errors <= REPORT_LIMIT)
                $display("%0t: unexpected hit col %0d row %0d pivot %0b frame %0b last %0b",
                         $time, got.hit_column, got.hit_row, got.hit_pivot,
                         got.hit_frame, got.hit_last);
        end
        else
        begin
            want = pending_hits.pop_front();
            if (got.hit_column !== want.hit_column || got.hit_row !== want.hit_row ||
                got.hit_pivot !== want.hit_pivot || got.hit_frame !== want.hit_frame ||
                got.hit_last !== want.hit_last)
            begin
                hit_errors++;
                if (hit_errors <= REPORT_LIMIT)
                begin
                    $display("%0t: hit mismatch", $time);
                    $display("  expected col %0d row %0d pivot %0b frame %0b last %0b",
                             want.hit_column, want.hit_row, want.hit_pivot,
                             want.hit_frame, want.hit_last);
                    $display("  actual   col %0d row %0d pivot %0b frame %0b last %0b",
                             got.hit_column, got.hit_row, got.hit_pivot,
                             got.hit_frame, got.hit_last);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_state = MODE_HEADER;
            runs_owed   = '0;
            cur_row     = '0;
            cur_pivot   = 1'b0;
            pivot_pixel = '0;
            hit_errors  = 0;
            pending_hits.delete();
            hits_owed   = 0;
        end
        else
        begin
            // a hit leaving now can't come from the word accepted at this edge
            if (out_valid && !out_stall)
                check_hit(out_data);
            if (in_valid && !in_stall)
                expand_word(in_data);
            // a header taken at this edge still sees the old pivot
            if (cfg_wr_en)
                pivot_pixel = cfg_wr_data;
            hits_owed = pending_hits.size();
        end
    end

endmodule

### tb/sv/sparse_pixel_frame_decoder_test.sv
// Top of the sparse pixel frame decoder test: clock, reset, frame stimulus
// with bursty input and patterned output stall, watchdog and verdict.
// Depends on spfd_pkg, sparse_pixel_frame_decoder and its checker module.
`timescale 1ns / 1ps

module sparse_pixel_frame_decoder_test;
    import spfd_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int SETTLE_CYCLES = 24;
    localparam int PHASE_WORDS  = 52;
    localparam int NUM_PHASES   = 6;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_t         in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_t        out_data;
    logic        cfg_wr_en = 1'b0;
    logic [13:0] cfg_wr_data = '0;

    int          hit_errors;
    int          hits_owed;
    int          hold_cycles = 0;
    in_t         word_q[$];

    sparse_pixel_frame_decoder u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    sparse_pixel_frame_decoder_check u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .hit_errors  (hit_errors),
        .hits_owed   (hits_owed)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] hdr_word(input logic [10:0] row, input logic [3:0] nruns);
        return {1'b0, row, nruns};
    endfunction

    function automatic logic [15:0] run_word(input logic [10:0] col, input logic [1:0] len);
        return {3'b000, col, len};
    endfunction

    task automatic push_word(input logic [15:0] w, input int left, input logic frame);
        in_t beat;
        beat.data_word  = w;
        beat.words_left = 11'(left);
        beat.frame_sel  = frame;
        word_q = {word_q, beat};
    endtask

    // One frame: mostly well-formed header/run groups, some cut short or
    // overrun, some pure noise with arbitrary counts.
    task automatic gen_frame(input int pivot_row);
        logic [15:0] body[$];
        int          kind;
        int          nrows;
        int          nruns;
        int          r;
        int          k;
        int          total;
        int          extra;
        int          row;
        logic        frame;
        kind  = $urandom_range(0, 9);
        frame = 1'($urandom_range(0, 1));
        if (kind == 0)
        begin
            total = $urandom_range(1, 8);
            for (k = 0; k < total; k++)
                push_word(16'($urandom_range(0, 65535)),
                          (k == total - 1 || $urandom_range(0, 3) == 0) ?
                              0 : $urandom_range(0, 2047), frame);
        end
        else
        begin
            nrows = $urandom_range(1, 4);
            for (r = 0; r < nrows; r++)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    row = pivot_row + $urandom_range(0, 2) - 1;
                    if (row < 0)
                        row = 0;
                    if (row > 2047)
                        row = 2047;
                end
                else
                    row = $urandom_range(0, 2047);
                nruns = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 15)
                                                     : $urandom_range(0, 3);
                body = {body, {1'($urandom_range(0, 1)), 11'(row), 4'(nruns)}};
                for (k = 0; k < nruns; k++)
                    body = {body, {3'($urandom_range(0, 7)), 11'($urandom_range(0, 2047)),
                                   2'($urandom_range(0, 3))}};
            end
            if (kind == 1 && body.size() > 1)
            begin
                // end the frame early: runs still owed or header overrun
                k = $urandom_range(1, body.size() - 1);
                while (body.size() > k)
                    void'(body.pop_back());
            end
            else if (kind == 2)
            begin
                body = {body, {1'b1, 11'($urandom_range(0, 2047)), 4'd15}};
                k = $urandom_range(1, 3);
                for (r = 0; r < k; r++)
                    body = {body, 16'($urandom_range(0, 65535))};
            end
            total = body.size();
            // sometimes start the count high; the last word still reads zero
            extra = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047 - total) : 0;
            for (k = 0; k < total; k++)
                push_word(body[k], (k == total - 1) ? 0 : extra + total - 1 - k, frame);
        end
    endtask

    task automatic send_words(input int gap_max);
        int idx;
        int burst_left;
        int gap_left;
        idx        = 0;
        burst_left = $urandom_range(1, 16);
        gap_left   = 0;
        while (idx < word_q.size())
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left--;
            end
            else
            begin
                in_valid <= 1'b1;
                in_data  <= word_q[idx];
            end
            @(posedge clk);
            if (in_valid && !in_stall)
            begin
                idx++;
                burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = (gap_max == 0 || $urandom_range(0, 3) == 0) ?
                                 0 : $urandom_range(1, gap_max);
                end
            end
        end
        in_valid <= 1'b0;
    endtask

    // The checker's count may not yet hold the last word, so wait for the clock
    // before looking at the count, then settle before a register write.
    task automatic wait_idle();
        @(posedge clk);
        while (hits_owed != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_pivot(input logic [13:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Receiver stall: changing styles, plus long hold-offs on request.
    initial
    begin
        int style;
        int style_left;
        style      = 0;
        style_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                hold_cycles--;
            end
            else
            begin
                if (style_left == 0)
                begin
                    style      = $urandom_range(0, 3);
                    style_left = $urandom_range(20, 120);
                end
                style_left--;
                case (style)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("sparse_pixel_frame_decoder_test failed");
        $finish;
    end

    initial
    begin
        int          phase;
        logic [13:0] pivot_now;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames, pivot row 100
        pivot_now = 14'd1600;
        write_pivot(pivot_now);
        // extremes: top row, column 2047 with a four-hit run, column 0 single hit
        push_word(hdr_word(11'd2047, 4'd2), 6, 1'b0);
        push_word(run_word(11'd2047, 2'd3), 5, 1'b0);
        push_word(run_word(11'd0, 2'd0), 4, 1'b0);
        // zero-run header below the pivot row, then one right at it
        push_word(hdr_word(11'd99, 4'd0), 3, 1'b0);
        push_word(hdr_word(11'd100, 4'd1), 2, 1'b0);
        push_word(run_word(11'd1234, 2'd1), 1, 1'b0);
        // last word while a header is expected: ignored
        push_word(16'hffff, 0, 1'b0);
        // header claims more runs than the frame holds: discard to frame end
        push_word(hdr_word(11'd5, 4'd15), 3, 1'b1);
        push_word(16'hffff, 2, 1'b1);
        push_word(16'h0000, 1, 1'b1);
        push_word(run_word(11'd7, 2'd3), 0, 1'b1);
        // frame ends with a run still owed
        push_word(hdr_word(11'd0, 4'd3), 5, 1'b1);
        push_word(run_word(11'd100, 2'd2), 4, 1'b1);
        push_word(run_word(11'd2000, 2'd3), 0, 1'b1);
        // run count equal to the words left is not an overrun
        push_word(hdr_word(11'd1024, 4'd1), 1, 1'b0);
        push_word(run_word(11'd1, 2'd3), 0, 1'b0);
        // one-word frame
        push_word(hdr_word(11'd3, 4'd1), 0, 1'b1);
        // largest count
        push_word(hdr_word(11'd500, 4'd1), 2047, 1'b0);
        push_word(run_word(11'd512, 2'd0), 2046, 1'b0);
        push_word(16'h8000, 0, 1'b0);
        send_words(3);

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_idle();
            case (phase)
                0:       pivot_now = 14'd9215;
                1:       pivot_now = 14'd0;
                3:       pivot_now = 14'd16;
                5:       pivot_now = 14'd9215;
                default: pivot_now = 14'($urandom_range(0, 9215));
            endcase
            write_pivot(pivot_now);
            word_q.delete();
            while (word_q.size() < PHASE_WORDS)
                gen_frame(pivot_now / 16);
            // long receiver hold-off while words keep coming: queue fills
            if (phase == 2)
                hold_cycles = 150;
            send_words((phase == 3) ? 0 : 6);
        end

        wait_idle();
        if (hit_errors == 0)
            $display("sparse_pixel_frame_decoder_test passed");
        else
            $display("sparse_pixel_frame_decoder_test failed");
        $finish;
    end

endmodule

### sim.f
design/spfd_pkg.sv
design/spfd_front.sv
design/spfd_queue.sv
design/spfd_back.sv
design/sparse_pixel_frame_decoder.sv
tb/sv/sparse_pixel_frame_decoder_check.sv
tb/sv/sparse_pixel_frame_decoder_test.sv
